// ----- rtl/core/int8_dot_product_requantize_assert.svh -----
// Assertion helpers used by the requantiser RTL.
`ifndef INT8_DOT_PRODUCT_REQUANTIZE_ASSERT_SVH
`define INT8_DOT_PRODUCT_REQUANTIZE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IDPR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("idpr: implication check failed");

// Next-cycle implication, checked out of reset.
`define IDPR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("idpr: next-cycle check failed");

`endif

// ----- rtl/core/idpr_pkg.sv -----
package idpr_pkg;

    localparam int LANES    = 4;
    localparam int ACT_W    = 8;
    localparam int WGT_W    = 8;
    localparam int PROD_W   = ACT_W + WGT_W + 1;
    localparam int SUM_W    = PROD_W + $clog2(LANES);
    localparam int ACC_W    = 32;
    localparam int BIAS_W   = 32;
    localparam int SCALE_W  = 32;
    localparam int MAG_W    = ACC_W + SCALE_W;
    localparam int OUT_W    = 8;
    localparam int ZP_W     = 8;
    localparam int SHIFT_W  = 6;
    localparam int TDATA_W  = LANES * (ACT_W + WGT_W) + BIAS_W + SCALE_W;
    localparam int ADDR_W   = 3;
    localparam int APB_W    = 32;

    localparam logic [ZP_W-1:0]    ZP_RESET    = '0;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(24);

    typedef logic signed [PROD_W-1:0] t_prod;

    typedef enum logic {
        REG_ZERO_POINT  = 1'b0,
        REG_SCALE_SHIFT = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_RND,
        ST_SAT
    } t_quant_state;

    typedef struct packed {
        logic [ZP_W-1:0]    zero_point;
        logic [SHIFT_W-1:0] scale_shift;
    } t_quant_cfg;

endpackage

// ----- rtl/core/int8_dot_product_requantize.sv -----
// int8 dot product with requantisation: one output byte of a 1x1 convolution.
// Slave stream: each transaction carries LANES activation/weight pairs plus the
// bias and scale of the output channel; tlast marks the final channel group.
// Master stream: one byte per tlast transaction, with the saturation flag in
// tuser. APB port: zero_point at 0x0, scale_shift at 0x4 (reset 0 and 24);
// write only while idle.
// Throughput: a non-final transaction is taken every cycle while the requantiser
// is idle. A tlast transaction keeps s_axis_tready low while the requantiser
// steps through bias add, 32x32 multiply, rounding and saturation; its result
// reaches the master side from the output register loaded in the saturation step.
// The output register holds one result, so accumulation goes on while it
// waits. If the receiver stalls, the next result waits in the saturation step
// and s_axis_tready stays low until the register frees.
// Reset (synchronous, active low) clears the accumulator, the sequencer, the
// output valid flag, and sets the registers to their reset values.
module int8_dot_product_requantize import idpr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // act0..act(LANES-1), weight0..weight(LANES-1), bias, scale
    input  logic [TDATA_W-1:0]  s_axis_tdata,
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // out_value
    output logic [OUT_W-1:0]    m_axis_tdata,
    // clipped
    output logic                m_axis_tuser,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [APB_W-1:0]    pwdata,
    output logic [APB_W-1:0]    prdata,
    output logic                pready
);

    localparam int WGT_BASE   = LANES * ACT_W;
    localparam int BIAS_BASE  = LANES * (ACT_W + WGT_W);
    localparam int SCALE_BASE = BIAS_BASE + BIAS_W;

    logic [ZP_W-1:0]    r_zero_point;
    logic [SHIFT_W-1:0] r_scale_shift;
    t_reg_idx           reg_idx;
    logic               cfg_wr;
    t_quant_cfg         qcfg;
    t_prod [LANES-1:0]  prod;
    logic [ACC_W-1:0]   total;
    logic               accept;
    logic               idle;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_point  <= ZP_RESET;
            r_scale_shift <= SHIFT_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_ZERO_POINT:  r_zero_point  <= pwdata[ZP_W-1:0];
                REG_SCALE_SHIFT: r_scale_shift <= pwdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ZERO_POINT:  prdata = APB_W'(r_zero_point);
            REG_SCALE_SHIFT: prdata = APB_W'(r_scale_shift);
            default:         prdata = '0;
        endcase
    end

    assign qcfg.zero_point  = r_zero_point;
    assign qcfg.scale_shift = r_scale_shift;

    assign s_axis_tready = idle;
    assign accept        = s_axis_tvalid && s_axis_tready;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        idpr_lane u_lane (
            .i_act    (s_axis_tdata[g*ACT_W +: ACT_W]),
            .i_weight ($signed(s_axis_tdata[WGT_BASE + g*WGT_W +: WGT_W])),
            .o_prod   (prod[g])
        );
    end

    idpr_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_prod   (prod),
        .i_accept (accept),
        .i_last   (s_axis_tlast),
        .o_total  (total)
    );

    idpr_requant u_requant (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (qcfg),
        .i_start  (accept && s_axis_tlast),
        .i_acc    (total),
        .i_bias   (s_axis_tdata[BIAS_BASE +: BIAS_W]),
        .i_scale  (s_axis_tdata[SCALE_BASE +: SCALE_W]),
        .o_idle   (idle),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_value  (m_axis_tdata),
        .o_clip   (m_axis_tuser)
    );

endmodule

// ----- rtl/core/idpr_lane.sv -----
module idpr_lane import idpr_pkg::*; (
    input  logic                    [ACT_W-1:0] i_act,
    input  logic signed             [WGT_W-1:0] i_weight,
    output t_prod                               o_prod
);

    // Zero-extend the activation so the product stays signed.
    assign o_prod = $signed({1'b0, i_act}) * i_weight;

endmodule

// ----- rtl/core/idpr_merge.sv -----
module idpr_merge import idpr_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_prod [LANES-1:0]       i_prod,
    input  logic                    i_accept,
    input  logic                    i_last,
    output logic [ACC_W-1:0]        o_total
);

    logic [ACC_W-1:0]        r_acc;
    logic [ACC_W-1:0]        n_acc;
    logic signed [SUM_W-1:0] lane_sum;

    always_comb begin
        lane_sum = '0;
        for (int i = 0; i < LANES; i++) begin
            lane_sum = lane_sum + SUM_W'(i_prod[i]);
        end
    end

    assign o_total = r_acc + ACC_W'(lane_sum);

    always_comb begin
        n_acc = r_acc;
        if (i_accept) begin
            // clear on the final group, the total moves on to requantisation
            n_acc = i_last ? '0 : o_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

endmodule

// ----- rtl/core/idpr_requant.sv -----
`include "int8_dot_product_requantize_assert.svh"

module idpr_requant import idpr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_quant_cfg          i_cfg,
    input  logic                i_start,
    input  logic [ACC_W-1:0]    i_acc,
    input  logic [BIAS_W-1:0]   i_bias,
    input  logic [SCALE_W-1:0]  i_scale,
    output logic                o_idle,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [OUT_W-1:0]    o_value,
    output logic                o_clip
);

    t_quant_state        r_state;
    t_quant_state        n_state;
    logic [ACC_W-1:0]    r_acc;
    logic [BIAS_W-1:0]   r_bias;
    logic [SCALE_W-1:0]  r_scale;
    logic                r_neg;
    logic [ACC_W-1:0]    r_mag32;
    logic [MAG_W-1:0]    r_mag;
    logic [MAG_W-1:0]    r_qt;
    logic                r_inc;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_value;
    logic                r_clip;

    logic [ACC_W-1:0]    sum;
    logic [MAG_W-1:0]    qt;
    logic                inc;
    logic [SHIFT_W-1:0]  sm1;
    logic [MAG_W-1:0]    low_mask;
    logic [MAG_W-1:0]    q;
    logic [OUT_W-1:0]    res;
    logic                clip;
    logic                load_out;

    // sum stage: wrap-add bias, split into sign and magnitude
    assign sum = r_acc + r_bias;

    // round stage: round half to even on the dropped fraction bits
    always_comb begin
        qt       = r_mag >> i_cfg.scale_shift;
        sm1      = i_cfg.scale_shift - SHIFT_W'(1);
        low_mask = (MAG_W'(1) << sm1) - MAG_W'(1);
        inc      = 1'b0;
        if (i_cfg.scale_shift != '0) begin
            inc = r_mag[sm1] && ((|(r_mag & low_mask)) || qt[0]);
        end
    end

    // saturate stage
    always_comb begin
        q    = r_qt + MAG_W'(r_inc);
        res  = '0;
        clip = 1'b0;
        if (r_neg) begin
            if (q > MAG_W'(i_cfg.zero_point)) begin
                res  = '0;
                clip = 1'b1;
            end else begin
                res = i_cfg.zero_point - q[OUT_W-1:0];
            end
        end else begin
            if (q > MAG_W'({OUT_W{1'b1}} - i_cfg.zero_point)) begin
                res  = '1;
                clip = 1'b1;
            end else begin
                res = q[OUT_W-1:0] + i_cfg.zero_point;
            end
        end
    end

    assign load_out = (r_state == ST_SAT) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: n_state = ST_MUL;
            ST_MUL: n_state = ST_RND;
            ST_RND: n_state = ST_SAT;
            ST_SAT: begin
                // hold until the output register is free
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_acc   <= i_acc;
            r_bias  <= i_bias;
            r_scale <= i_scale;
        end
        if (r_state == ST_SUM) begin
            r_neg   <= sum[ACC_W-1];
            r_mag32 <= sum[ACC_W-1] ? (ACC_W'(0) - sum) : sum;
        end
        if (r_state == ST_MUL) begin
            r_mag <= MAG_W'(r_mag32) * MAG_W'(r_scale);
        end
        if (r_state == ST_RND) begin
            r_qt  <= qt;
            r_inc <= inc;
        end
        if (load_out) begin
            r_out_value <= res;
            r_clip      <= clip;
        end
    end

    assign o_idle  = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_clip  = r_clip;

    `IDPR_ASSERT_IMP(a_start_when_idle, i_start && !o_idle, 1'b0)
    `IDPR_ASSERT_NXT(a_sat_holds, r_state == ST_SAT && r_out_valid && !i_ready,
                     r_state == ST_SAT && r_out_valid)
    `IDPR_ASSERT_NXT(a_sat_delivers, load_out, r_out_valid && r_state == ST_IDLE)
    `IDPR_ASSERT_IMP(a_clip_rails, r_out_valid && r_clip,
                     r_out_value == '0 || r_out_value == '1)

endmodule
